FILE: rtl/tcg_pkg.sv
// Shared types and constants of the turntable CV generator.
package tcg_pkg;

	// Operation codes carried in the op field of an input transaction.
	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	// Direction codes of the deadband classifier.
	localparam logic [1:0] DIR_NONE = 2'b00;
	localparam logic [1:0] DIR_POS  = 2'b01;
	localparam logic [1:0] DIR_NEG  = 2'b10;

	// Configuration register indexes (byte address divided by four).
	localparam logic [2:0] REG_FILTER_ALPHA = 3'd0;
	localparam logic [2:0] REG_ACCEL_GAIN   = 3'd1;
	localparam logic [2:0] REG_DIR_THRESH   = 3'd2;
	localparam logic [2:0] REG_GATE_THRESH  = 3'd3;
	localparam logic [2:0] REG_PULSE_LENGTH = 3'd4;

	// Full-scale level and speed limits.
	localparam logic [14:0]        LEVEL_MAX     = 15'd32767;
	localparam logic signed [15:0] PITCH_MIN     = -16'sd32768;
	localparam logic signed [15:0] PITCH_CLAMP   = -16'sd32767;
	localparam logic signed [25:0] ACCEL_MAX     = 26'sd32767;
	localparam logic signed [25:0] ACCEL_MIN     = -26'sd32767;
	localparam logic signed [26:0] SPEED_LIM_POS = 27'sd8388352;
	localparam logic signed [26:0] SPEED_LIM_NEG = -27'sd8388352;

	// Configuration register file contents.
	typedef struct packed {
		logic [15:0] filter_alpha;
		logic [7:0]  accel_gain;
		logic [14:0] direction_threshold;
		logic [14:0] gate_threshold;
		logic [15:0] pulse_length;
	} tcg_cfg_t;

	// One input transaction.
	typedef struct packed {
		logic               op;
		logic signed [15:0] pitch;
		logic [11:0]        platter_angle;
		logic [31:0]        play_position;
		logic [31:0]        play_length;
		logic [14:0]        fader_level;
		logic [14:0]        xfade_pos;
	} tcg_item_t;

	// One result transaction.
	typedef struct packed {
		logic signed [15:0] speed_cv;
		logic [14:0]        angle_cv;
		logic signed [15:0] accel_cv;
		logic [14:0]        position_cv;
		logic [14:0]        crossfader_cv;
		logic               gate_scratch;
		logic               gate_beat;
		logic               reverse_pulse;
	} tcg_result_t;

	// Classified command handed from the front end to the back end.
	typedef struct packed {
		logic               op;
		logic signed [15:0] pitch;
		logic [11:0]        angle;
		logic [31:0]        pos;
		logic [31:0]        len;
		logic [14:0]        volume;
		logic [1:0]         dir;
		logic               scratch;
		logic               beat;
		logic               pos_zero;
		logic               pos_full;
	} tcg_cmd_t;

endpackage

FILE: rtl/tcg_fifo.sv
// Small register-based FIFO with push/full and pop/empty sides.
module tcg_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Storage is written on every accepted push.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers wrap at the depth; the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

FILE: rtl/tcg_front.sv
// Front end: accepts input transactions, classifies them and queues commands.
module tcg_front #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tcg_pkg::tcg_cfg_t   cfg,
	input  logic                push,
	input  tcg_pkg::tcg_item_t  item,
	output logic                full,
	input  logic                cmd_pop,
	output tcg_pkg::tcg_cmd_t   cmd,
	output logic                cmd_empty
);
	import tcg_pkg::*;

	tcg_cmd_t           cls;
	logic signed [15:0] pitch_c;
	logic signed [16:0] pitch_x;
	logic signed [16:0] thr_x;
	logic [15:0]        beat_lim;

	// Pitch clamp, deadband direction, gates and position special cases.
	always_comb begin
		pitch_c  = (item.pitch == PITCH_MIN) ? PITCH_CLAMP : item.pitch;
		pitch_x  = {pitch_c[15], pitch_c};
		thr_x    = {2'b00, cfg.direction_threshold};
		beat_lim = {1'b0, LEVEL_MAX} - {1'b0, cfg.gate_threshold};

		cls.op       = item.op;
		cls.pitch    = pitch_c;
		cls.angle    = item.platter_angle;
		cls.pos      = item.play_position;
		cls.len      = item.play_length;
		cls.volume   = item.fader_level;
		cls.scratch  = (item.xfade_pos > cfg.gate_threshold);
		cls.beat     = ({1'b0, item.xfade_pos} < beat_lim);
		cls.pos_zero = (item.play_length == '0);
		cls.pos_full = (item.play_position >= item.play_length);
		priority if (pitch_x > thr_x) begin
			cls.dir = DIR_POS;
		end else if (pitch_x < -thr_x) begin
			cls.dir = DIR_NEG;
		end else begin
			cls.dir = DIR_NONE;
		end
	end

	// Command queue toward the back end.
	tcg_fifo #(
		.WIDTH($bits(tcg_cmd_t)),
		.DEPTH(DEPTH)
	) u_cmd_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cls),
		.full  (full),
		.pop   (cmd_pop),
		.rdata (cmd),
		.empty (cmd_empty)
	);
endmodule

FILE: rtl/tcg_back.sv
// Back end: sequencer that applies updates and steps the filter on ticks.
module tcg_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tcg_pkg::tcg_cfg_t    cfg,
	input  tcg_pkg::tcg_cmd_t    cmd,
	input  logic                 cmd_empty,
	output logic                 cmd_pop,
	input  logic                 res_full,
	output logic                 res_push,
	output tcg_pkg::tcg_result_t res
);
	import tcg_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_UPD_MUL  = 6'b000010,
		ST_UPD_FIN  = 6'b000100,
		ST_UPD_DIV  = 6'b001000,
		ST_TICK_MUL = 6'b010000,
		ST_TICK_OUT = 6'b100000
	} state_t;

	state_t             state_q;
	tcg_cmd_t           cmd_q;

	// Architectural state.
	logic signed [15:0] target_q;
	logic signed [23:0] smoothed_q;
	logic [11:0]        angle_q;
	logic signed [15:0] accel_q;
	logic [14:0]        position_q;
	logic [14:0]        volume_q;
	logic               scratch_q;
	logic               beat_q;
	logic [1:0]         last_dir_q;
	logic [15:0]        pulse_q;

	// Working registers.
	logic signed [25:0] accel_prod_q;
	logic [46:0]        num_q;
	logic [31:0]        rem_q;
	logic [14:0]        low_q;
	logic [14:0]        quo_q;
	logic [3:0]         bit_q;
	logic signed [41:0] prod_q;

	logic signed [16:0] diff;
	logic signed [24:0] dspeed;
	logic [32:0]        trial;
	logic               ge;
	logic signed [41:0] prod_adj;
	logic signed [26:0] s_sum;
	logic signed [23:0] s_cl;
	logic signed [23:0] s_bias;
	logic [26:0]        angle_mul;

	// Datapath terms of each step.
	always_comb begin
		diff      = {cmd_q.pitch[15], cmd_q.pitch} - {target_q[15], target_q};
		dspeed    = {target_q[15], target_q, 8'd0} - {smoothed_q[23], smoothed_q};
		trial     = {rem_q, low_q[14]};
		ge        = (trial >= {1'b0, cmd_q.len});
		prod_adj  = prod_q[41] ? (prod_q + 42'sd65535) : prod_q;
		s_sum     = {{3{smoothed_q[23]}}, smoothed_q} + {prod_adj[41], prod_adj[41:16]};
		priority if (s_sum > SPEED_LIM_POS) begin
			s_cl = SPEED_LIM_POS[23:0];
		end else if (s_sum < SPEED_LIM_NEG) begin
			s_cl = SPEED_LIM_NEG[23:0];
		end else begin
			s_cl = s_sum[23:0];
		end
		s_bias    = s_cl[23] ? (s_cl + 24'sd255) : s_cl;
		angle_mul = {angle_q, 15'd0} - {15'd0, angle_q};
	end

	// Result assembly and handshakes.
	always_comb begin
		res.speed_cv      = s_bias[23:8];
		res.angle_cv      = angle_mul[26:12];
		res.accel_cv      = accel_q;
		res.position_cv   = position_q;
		res.crossfader_cv = volume_q;
		res.gate_scratch  = scratch_q;
		res.gate_beat     = beat_q;
		res.reverse_pulse = (pulse_q != '0);
		cmd_pop  = (state_q == ST_IDLE) && !cmd_empty;
		res_push = (state_q == ST_TICK_OUT) && !res_full;
	end

	// Payload and working registers.
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (state_q == ST_UPD_MUL) begin
			accel_prod_q <= {{9{diff[16]}}, diff} * $signed({18'd0, cfg.accel_gain});
			num_q        <= {cmd_q.pos, 15'd0} - {15'd0, cmd_q.pos};
		end
		if (state_q == ST_TICK_MUL) begin
			prod_q <= {{17{dspeed[24]}}, dspeed} * $signed({26'd0, cfg.filter_alpha});
		end
		if (state_q == ST_UPD_FIN) begin
			rem_q <= num_q[46:15];
			low_q <= num_q[14:0];
			bit_q <= 4'd14;
		end
		if (state_q == ST_UPD_DIV) begin
			rem_q <= ge ? 32'(trial - {1'b0, cmd_q.len}) : trial[31:0];
			low_q <= {low_q[13:0], 1'b0};
			quo_q <= {quo_q[13:0], ge};
			bit_q <= bit_q - 1'b1;
		end
	end

	// Sequencer and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			target_q   <= '0;
			smoothed_q <= '0;
			angle_q    <= '0;
			accel_q    <= '0;
			position_q <= '0;
			volume_q   <= '0;
			scratch_q  <= 1'b0;
			beat_q     <= 1'b0;
			last_dir_q <= DIR_NONE;
			pulse_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!cmd_empty) begin
						state_q <= (cmd.op == OP_TICK) ? ST_TICK_MUL : ST_UPD_MUL;
					end
				end
				ST_UPD_MUL: begin
					target_q  <= cmd_q.pitch;
					angle_q   <= cmd_q.angle;
					volume_q  <= cmd_q.volume;
					scratch_q <= cmd_q.scratch;
					beat_q    <= cmd_q.beat;
					// A reversal between two nonzero directions reloads the pulse.
					if (last_dir_q != DIR_NONE && cmd_q.dir != DIR_NONE &&
					    last_dir_q != cmd_q.dir) begin
						pulse_q <= cfg.pulse_length;
					end
					last_dir_q <= cmd_q.dir;
					state_q    <= ST_UPD_FIN;
				end
				ST_UPD_FIN: begin
					priority if (accel_prod_q > ACCEL_MAX) begin
						accel_q <= ACCEL_MAX[15:0];
					end else if (accel_prod_q < ACCEL_MIN) begin
						accel_q <= ACCEL_MIN[15:0];
					end else begin
						accel_q <= accel_prod_q[15:0];
					end
					priority if (cmd_q.pos_zero) begin
						position_q <= '0;
						state_q    <= ST_IDLE;
					end else if (cmd_q.pos_full) begin
						position_q <= LEVEL_MAX;
						state_q    <= ST_IDLE;
					end else begin
						state_q <= ST_UPD_DIV;
					end
				end
				ST_UPD_DIV: begin
					// One quotient bit per cycle, most significant first.
					if (bit_q == '0) begin
						position_q <= {quo_q[13:0], ge};
						state_q    <= ST_IDLE;
					end
				end
				ST_TICK_MUL: begin
					state_q <= ST_TICK_OUT;
				end
				ST_TICK_OUT: begin
					if (!res_full) begin
						smoothed_q <= s_cl;
						if (pulse_q != '0) begin
							pulse_q <= pulse_q - 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

FILE: rtl/turntable_cv_generator_unit.sv
// Top level of the turntable CV generator: register file, front end, back end, result queue.
//
// Input transactions enter through push/full: an item is taken at a clock
// edge with push high and full low. A controller update (op 0) refreshes
// the stored pitch, acceleration, direction, reversal pulse, position and
// gates and yields no result. An output frame tick (op 1) steps the speed
// lowpass and yields one result with all CV levels and gates.
// Results leave through empty/pop: the oldest result is on the result
// port while empty is low and is taken at an edge with pop high.
// The back-end sequencer takes a tick through its multiply and output states
// and an update through its multiply and finish states, then through the
// bit-serial divider when the position fraction needs it (15 quotient bits,
// one per cycle); a tick result is pushed from the output state.
// A command queue of CMD_DEPTH entries lets the front keep accepting while
// the back end works; when the result queue (RES_DEPTH entries) is full,
// the back end waits on its tick and the command queue then fills.
// Reset clears all control and architectural state and loads register defaults; no clearing pass.
// Configuration uses an APB-style port, registers at byte address 4*i.
module turntable_cv_generator_unit #(
	parameter int CMD_DEPTH = 4,
	parameter int RES_DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [4:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 push,
	input  tcg_pkg::tcg_item_t   item,
	output logic                 full,
	input  logic                 pop,
	output tcg_pkg::tcg_result_t result,
	output logic                 empty
);
	import tcg_pkg::*;

	tcg_cfg_t    cfg_q;
	logic [2:0]  reg_idx;
	logic        wr_en;
	tcg_cmd_t    cmd;
	logic        cmd_empty;
	logic        cmd_pop;
	logic        res_full;
	logic        res_push;
	tcg_result_t res;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// Register writes; addresses past the last register are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_alpha        <= 16'd1000;
			cfg_q.accel_gain          <= 8'd10;
			cfg_q.direction_threshold <= 15'd328;
			cfg_q.gate_threshold      <= 15'd16384;
			cfg_q.pulse_length        <= 16'd480;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_FILTER_ALPHA: cfg_q.filter_alpha        <= pwdata[15:0];
				REG_ACCEL_GAIN:   cfg_q.accel_gain          <= pwdata[7:0];
				REG_DIR_THRESH:   cfg_q.direction_threshold <= pwdata[14:0];
				REG_GATE_THRESH:  cfg_q.gate_threshold      <= pwdata[14:0];
				REG_PULSE_LENGTH: cfg_q.pulse_length        <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// Register readback.
	always_comb begin
		unique case (reg_idx)
			REG_FILTER_ALPHA: prdata = {16'd0, cfg_q.filter_alpha};
			REG_ACCEL_GAIN:   prdata = {24'd0, cfg_q.accel_gain};
			REG_DIR_THRESH:   prdata = {17'd0, cfg_q.direction_threshold};
			REG_GATE_THRESH:  prdata = {17'd0, cfg_q.gate_threshold};
			REG_PULSE_LENGTH: prdata = {16'd0, cfg_q.pulse_length};
			default:          prdata = '0;
		endcase
	end

	tcg_front #(
		.DEPTH(CMD_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.push     (push),
		.item     (item),
		.full     (full),
		.cmd_pop  (cmd_pop),
		.cmd      (cmd),
		.cmd_empty(cmd_empty)
	);

	tcg_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd      (cmd),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res)
	);

	// Result queue toward the consumer.
	tcg_fifo #(
		.WIDTH($bits(tcg_result_t)),
		.DEPTH(RES_DEPTH)
	) u_res_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res),
		.full  (res_full),
		.pop   (pop),
		.rdata (result),
		.empty (empty)
	);
endmodule

FILE: sim/tcg_checker.sv
// Checker for the turntable CV generator: predicts every result and compares it.
module tcg_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic                 pready,
	input  logic [4:0]           paddr,
	input  logic [31:0]          pwdata,
	input  logic                 push,
	input  logic                 full,
	input  tcg_pkg::tcg_item_t   item,
	input  logic                 pop,
	input  logic                 empty,
	input  tcg_pkg::tcg_result_t result,
	output int                   fails,
	output int                   pending
);
	import tcg_pkg::*;

	// Local copy of the register file.
	tcg_cfg_t cfg;

	// Local copy of the generator state, at the block's own widths.
	logic signed [15:0] tgt_pitch;
	logic signed [23:0] smooth_speed;
	logic [11:0]        angle_hold;
	logic signed [15:0] accel_hold;
	logic [14:0]        pos_frac;
	logic [14:0]        vol_hold;
	logic               scratch_gate;
	logic               beat_gate;
	logic [1:0]         prev_dir;
	logic [15:0]        pulse_left;

	// Frame results predicted but not yet popped, oldest first.
	tcg_result_t frame_q[$];

	// Reports one field that differs from its prediction.
	task automatic flag(input string field, input longint want, input longint seen);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
		fails++;
	endtask

	// A controller update refreshes the stored levels and gates and arms the pulse on a reversal.
	task automatic take_update(input tcg_item_t it);
		longint      p;
		longint      acc;
		longint      thr;
		logic [1:0]  dir;
		logic [63:0] num;
		p = (it.pitch == PITCH_MIN) ? longint'(PITCH_CLAMP) : longint'(it.pitch);
		thr = longint'(cfg.direction_threshold);
		acc = (p - longint'(tgt_pitch)) * longint'(cfg.accel_gain);
		if (acc > 32767) begin
			acc = 32767;
		end else if (acc < -32767) begin
			acc = -32767;
		end
		accel_hold = 16'(acc);
		tgt_pitch = 16'(p);
		angle_hold = it.platter_angle;

		// Deadband classification; a flip between two real directions reloads the pulse.
		dir = DIR_NONE;
		if (p > thr) begin
			dir = DIR_POS;
		end else if (p < -thr) begin
			dir = DIR_NEG;
		end
		if (prev_dir != DIR_NONE && dir != DIR_NONE && prev_dir != dir) begin
			pulse_left = cfg.pulse_length;
		end
		prev_dir = dir;

		// Playback fraction, zero for an empty length and pinned at full scale once the end is reached.
		if (it.play_length == 32'd0) begin
			pos_frac = 15'd0;
		end else if (it.play_position >= it.play_length) begin
			pos_frac = LEVEL_MAX;
		end else begin
			num = 64'(it.play_position) * 64'(LEVEL_MAX);
			pos_frac = 15'(num / 64'(it.play_length));
		end

		vol_hold = it.fader_level;
		scratch_gate = it.xfade_pos > cfg.gate_threshold;
		beat_gate = it.xfade_pos < (LEVEL_MAX - cfg.gate_threshold);
	endtask

	// A frame tick steps the speed lowpass and yields one result.
	task automatic take_tick(output tcg_result_t r);
		longint d;
		longint s;
		d = longint'(tgt_pitch) * 256 - longint'(smooth_speed);
		s = longint'(smooth_speed) + (d * longint'(cfg.filter_alpha)) / 65536;
		if (s > longint'(SPEED_LIM_POS)) begin
			s = longint'(SPEED_LIM_POS);
		end else if (s < longint'(SPEED_LIM_NEG)) begin
			s = longint'(SPEED_LIM_NEG);
		end
		smooth_speed = 24'(s);
		r.speed_cv = 16'(s / 256);
		r.angle_cv = 15'((32'(angle_hold) * 32'(LEVEL_MAX)) >> 12);
		r.accel_cv = accel_hold;
		r.position_cv = pos_frac;
		r.crossfader_cv = vol_hold;
		r.gate_scratch = scratch_gate;
		r.gate_beat = beat_gate;
		r.reverse_pulse = (pulse_left != 16'd0);
		if (pulse_left != 16'd0) begin
			pulse_left = pulse_left - 16'd1;
		end
	endtask

	// Watch both queues and the register port on every rising edge.
	always @(posedge clk or negedge arst_n) begin : watch
		tcg_result_t want;
		tcg_result_t fresh;
		if (!arst_n) begin
			cfg.filter_alpha = 16'd1000;
			cfg.accel_gain = 8'd10;
			cfg.direction_threshold = 15'd328;
			cfg.gate_threshold = 15'd16384;
			cfg.pulse_length = 16'd480;
			tgt_pitch = '0;
			smooth_speed = '0;
			angle_hold = '0;
			accel_hold = '0;
			pos_frac = '0;
			vol_hold = '0;
			scratch_gate = 1'b0;
			beat_gate = 1'b0;
			prev_dir = DIR_NONE;
			pulse_left = '0;
			frame_q.delete();
			pending = 0;
		end else begin
			// Register writes.
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_FILTER_ALPHA: cfg.filter_alpha = pwdata[15:0];
					REG_ACCEL_GAIN:   cfg.accel_gain = pwdata[7:0];
					REG_DIR_THRESH:   cfg.direction_threshold = pwdata[14:0];
					REG_GATE_THRESH:  cfg.gate_threshold = pwdata[14:0];
					REG_PULSE_LENGTH: cfg.pulse_length = pwdata[15:0];
					default: ;
				endcase
			end

			// Result transactions are compared against the oldest prediction.
			if (pop && !empty) begin
				if (frame_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %p", $time, result);
					fails++;
				end else begin
					want = frame_q.pop_front();
					if (result.speed_cv !== want.speed_cv)
						flag("speed_cv", want.speed_cv, result.speed_cv);
					if (result.angle_cv !== want.angle_cv)
						flag("angle_cv", want.angle_cv, result.angle_cv);
					if (result.accel_cv !== want.accel_cv)
						flag("accel_cv", want.accel_cv, result.accel_cv);
					if (result.position_cv !== want.position_cv)
						flag("position_cv", want.position_cv, result.position_cv);
					if (result.crossfader_cv !== want.crossfader_cv)
						flag("crossfader_cv", want.crossfader_cv, result.crossfader_cv);
					if (result.gate_scratch !== want.gate_scratch)
						flag("gate_scratch", want.gate_scratch, result.gate_scratch);
					if (result.gate_beat !== want.gate_beat)
						flag("gate_beat", want.gate_beat, result.gate_beat);
					if (result.reverse_pulse !== want.reverse_pulse)
						flag("reverse_pulse", want.reverse_pulse, result.reverse_pulse);
				end
			end

			// Accepted input transactions advance the prediction.
			if (push && !full) begin
				if (item.op == OP_TICK) begin
					take_tick(fresh);
					frame_q.push_back(fresh);
				end else begin
					take_update(item);
				end
			end
			pending = frame_q.size();
		end
	end

endmodule

FILE: sim/tb_turntable_cv_generator_unit.sv
// Testbench top for the turntable CV generator: stimulus, pacing and the verdict.
module tb_turntable_cv_generator_unit;
	import tcg_pkg::*;

	localparam int CYCLE_LIMIT   = 800000;
	localparam int SETTLE_CYCLES = 100;
	localparam int HOLD_CYCLES   = 400;
	localparam int PHASE_ITEMS   = 150;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        push = 1'b0;
	tcg_item_t   item = '0;
	logic        full;
	logic        pop = 1'b0;
	tcg_result_t result;
	logic        empty;

	int fails;
	int pending;
	int cycles = 0;

	// Settings currently loaded, used to aim stimulus at the thresholds.
	tcg_cfg_t cfg_now;
	int       last_pitch = 0;
	logic     hold_request = 1'b0;
	logic     tx_steady = 1'b0;
	logic     rx_steady = 1'b0;

	turntable_cv_generator_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.push    (push),
		.item    (item),
		.full    (full),
		.pop     (pop),
		.result  (result),
		.empty   (empty)
	);

	tcg_checker i_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.pready  (pready),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.push    (push),
		.full    (full),
		.item    (item),
		.pop     (pop),
		.empty   (empty),
		.result  (result),
		.fails   (fails),
		.pending (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Mostly short pauses, now and then a long one.
	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Receiver: random stalls, steady popping on request, and one long hold-off.
	initial begin : receiver
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else begin
				pop <= 1'b1;
				if (!rx_steady && $urandom_range(0, 2) == 0) stall_left = pause_len();
			end
		end
	end

	// Offers one input transaction and waits until it is taken.
	task automatic offer(input tcg_item_t it);
		int gap;
		gap = tx_steady ? 0 : pause_len();
		if (gap > 0) begin
			@(negedge clk);
			push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
	endtask

	// Stops sending, lets every frame drain and the back end go quiet.
	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic load_settings(input tcg_cfg_t c);
		drain();
		write_reg(REG_FILTER_ALPHA, 32'(c.filter_alpha));
		write_reg(REG_ACCEL_GAIN, 32'(c.accel_gain));
		write_reg(REG_DIR_THRESH, 32'(c.direction_threshold));
		write_reg(REG_GATE_THRESH, 32'(c.gate_threshold));
		write_reg(REG_PULSE_LENGTH, 32'(c.pulse_length));
		cfg_now = c;
	endtask

	function automatic tcg_item_t update_of(input int p, input logic [11:0] ang,
			input logic [31:0] pos, input logic [31:0] len, input logic [14:0] vol,
			input logic [14:0] xf);
		tcg_item_t it;
		it.op = OP_UPDATE;
		it.pitch = 16'(p);
		it.platter_angle = ang;
		it.play_position = pos;
		it.play_length = len;
		it.fader_level = vol;
		it.xfade_pos = xf;
		return it;
	endfunction

	// Frame tick; the other fields carry noise the block must ignore.
	function automatic tcg_item_t frame_tick();
		tcg_item_t it;
		it.op = OP_TICK;
		it.pitch = 16'($urandom);
		it.platter_angle = 12'($urandom);
		it.play_position = $urandom;
		it.play_length = $urandom;
		it.fader_level = 15'($urandom);
		it.xfade_pos = 15'($urandom);
		return it;
	endfunction

	// Random update aimed at clamps, deadband edges, reversals and gate edges.
	function automatic tcg_item_t random_update();
		tcg_item_t it;
		int        v;
		int        thr;
		int        gt;
		thr = int'(cfg_now.direction_threshold);
		gt = int'(cfg_now.gate_threshold);
		it = frame_tick();
		it.op = OP_UPDATE;
		case ($urandom_range(0, 9))
			0: v = -32768;
			1: v = 32767;
			2: v = -32767;
			3: v = thr + int'($urandom_range(0, 2)) - 1;
			4: v = -thr + int'($urandom_range(0, 2)) - 1;
			5, 6: v = -last_pitch + int'($urandom_range(0, 64)) - 32;
			default: v = int'($signed(16'($urandom)));
		endcase
		it.pitch = 16'(v);
		last_pitch = int'(it.pitch);

		case ($urandom_range(0, 5))
			0: it.play_length = 32'd0;
			1: it.play_position = $urandom_range(32'hFFFF_FFFF, it.play_length);
			2: begin
				it.play_length = $urandom_range(1, 100);
				it.play_position = $urandom_range(0, it.play_length - 1);
			end
			default: begin
				if (it.play_length == 32'd0) it.play_length = 32'd1;
				it.play_position = $urandom_range(0, it.play_length - 1);
			end
		endcase

		case ($urandom_range(0, 5))
			0: v = gt + int'($urandom_range(0, 2)) - 1;
			1: v = 32767 - gt + int'($urandom_range(0, 2)) - 1;
			2: v = 0;
			3: v = 32767;
			default: v = int'($urandom_range(0, 32767));
		endcase
		it.xfade_pos = 15'(v);
		return it;
	endfunction

	task automatic random_run(input int count);
		repeat (count) begin
			if ($urandom_range(0, 1) == 1) offer(frame_tick());
			else offer(random_update());
		end
	endtask

	initial begin : stimulus
		tcg_cfg_t plan [7];
		plan[0] = '{filter_alpha: 16'hFFFF, accel_gain: 8'hFF, direction_threshold: 15'd0,
			gate_threshold: 15'd0, pulse_length: 16'd1};
		plan[1] = '{filter_alpha: 16'd0, accel_gain: 8'd0, direction_threshold: 15'h7FFF,
			gate_threshold: 15'h7FFF, pulse_length: 16'd0};
		plan[2] = '{filter_alpha: 16'd1, accel_gain: 8'd1, direction_threshold: 15'd1,
			gate_threshold: 15'd32766, pulse_length: 16'hFFFF};
		plan[3] = '{filter_alpha: 16'd40000, accel_gain: 8'd128, direction_threshold: 15'd1000,
			gate_threshold: 15'd8000, pulse_length: 16'd3};
		plan[4] = '{filter_alpha: 16'($urandom), accel_gain: 8'($urandom),
			direction_threshold: 15'($urandom), gate_threshold: 15'($urandom),
			pulse_length: 16'($urandom_range(0, 40))};
		plan[5] = '{filter_alpha: 16'($urandom), accel_gain: 8'($urandom),
			direction_threshold: 15'($urandom_range(0, 2000)),
			gate_threshold: 15'($urandom), pulse_length: 16'($urandom_range(0, 8))};
		plan[6] = '{filter_alpha: 16'd12000, accel_gain: 8'd10, direction_threshold: 15'd328,
			gate_threshold: 15'd16384, pulse_length: 16'd20};
		cfg_now = '{filter_alpha: 16'd1000, accel_gain: 8'd10, direction_threshold: 15'd328,
			gate_threshold: 15'd16384, pulse_length: 16'd480};

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part under the reset settings.
		offer(frame_tick());
		// Most negative pitch is clamped; no sample loaded.
		offer(update_of(-32768, 12'hFFF, 32'd0, 32'd0, 15'h7FFF, 15'h7FFF));
		offer(frame_tick());
		// Full-swing reversal with saturated acceleration; position at the end.
		offer(update_of(32767, 12'h000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 15'h0000, 15'h0000));
		offer(frame_tick());
		offer(frame_tick());
		// Inside the deadband; crossfader exactly on the threshold.
		offer(update_of(0, 12'hAAA, 32'd1, 32'hFFFF_FFFF, 15'h5555, 15'd16384));
		offer(frame_tick());
		offer(update_of(328, 12'h555, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 15'h2AAA, 15'd16385));
		// Leaving the deadband does not count as a reversal; position past the end.
		offer(update_of(329, 12'd1, 32'd7, 32'd3, 15'd1, 15'd16383));
		offer(update_of(-329, 12'd2, 32'd2, 32'd3, 15'd2, 15'd16382));
		offer(frame_tick());
		offer(update_of(-328, 12'd3, 32'd0, 32'd1, 15'd3, 15'd16383));
		offer(frame_tick());
		offer(update_of(-32767, 12'hFFE, 32'd12345, 32'd1000000, 15'd32766, 15'd1));
		offer(frame_tick());
		offer(frame_tick());

		random_run(PHASE_ITEMS - 10);

		for (int k = 0; k < 7; k++) begin
			load_settings(plan[k]);
			if (k == 3) begin
				// No idling on either side for this stretch.
				tx_steady = 1'b1;
				rx_steady = 1'b1;
			end
			if (k == 6) begin
				// Receiver holds off while ticks keep coming, so the block backs up.
				hold_request = 1'b1;
				tx_steady = 1'b1;
				repeat (40) offer(frame_tick());
				tx_steady = 1'b0;
			end
			random_run(PHASE_ITEMS);
			tx_steady = 1'b0;
			rx_steady = 1'b0;
		end

		drain();
		if (fails == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
